// ===== design/edf_pkg.sv =====
// ============================================================================
// edf_pkg: shared types and constants for the EDF task scheduler
// Operation codes, default sizes and the queued-command record.
// ============================================================================
`default_nettype none
package edf_pkg;
	localparam int DEF_TASK_SLOTS      = 16;
	localparam int DEF_PRIORITY_LEVELS = 8;
	localparam int DEF_CORE_COUNT      = 4;
	localparam logic [63:0] NO_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFE;
	localparam logic [63:0] NEVER_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [2:0] AFF_ANY = 3'b111;

	typedef enum logic [1:0] {
		OP_ENQUEUE  = 2'd0,
		OP_SCHEDULE = 2'd1,
		OP_EXIT     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  core;
		logic [3:0]  slot;
		logic [2:0]  level;
		logic [2:0]  aff;
		logic [63:0] deadline;
	} cmd_t;
endpackage
`default_nettype wire

// ===== design/edf_front.sv =====
// ============================================================================
// edf_front: command intake
// Captures a transaction into a two-entry queue toward the engine.
// ============================================================================
`default_nettype none
module edf_front
	import edf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  operation,
	input  wire logic [1:0]  core,
	input  wire logic [3:0]  task_slot,
	input  wire logic [2:0]  priority_req,
	input  wire logic [2:0]  affinity,
	input  wire logic [63:0] deadline,
	output logic             busy,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_pop
);
	cmd_t       fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{op: op_t'(operation), core: core, slot: task_slot,
				level: priority_req, aff: affinity, deadline: deadline};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("pop from empty command queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> cmd_valid)
		else $error("pushed command lost");
endmodule
`default_nettype wire

// ===== design/edf_engine.sv =====
// ============================================================================
// edf_engine: task table and schedule sequencer
// Runs enqueue, and two EDF scans plus a fallback scan over the table.
// ============================================================================
`default_nettype none
module edf_engine
	import edf_pkg::*;
#(
	parameter int TASK_SLOTS      = DEF_TASK_SLOTS,
	parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
	parameter int CORE_COUNT      = DEF_CORE_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             done,
	output logic [3:0]       cur_task,
	output logic             idle_selected,
	output logic             switched,
	output logic             rejected
);
	localparam int SW = $clog2(TASK_SLOTS);
	localparam int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

	typedef enum logic [2:0] {S_IDLE, S_REQ, S_SCAN, S_PICK, S_OUT} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [1:0]      pass_q;      // 0 skip caller, 1 allow caller, 2 fallback
	logic [SW-1:0]   idx_q;
	logic            found_q;
	logic [SW-1:0]   best_q;
	logic [63:0]     best_dl_q, best_ls_q;
	logic [2:0]      best_lv_q;
	logic [31:0]     best_age_q;

	logic [TASK_SLOTS-1:0] queued_q;
	logic [1:0]      qcore_q  [TASK_SLOTS];
	logic [2:0]      level_q  [TASK_SLOTS];
	logic [2:0]      aff_q    [TASK_SLOTS];
	logic [63:0]     dl_q     [TASK_SLOTS];
	logic [63:0]     lsw_q    [TASK_SLOTS];
	logic [31:0]     stamp_q  [TASK_SLOTS];
	logic [31:0]     fifo_cnt_q;
	logic [63:0]     sw_cnt_q;
	logic [SW:0]     cur_q    [CORE_COUNT];
	logic [CORE_COUNT-1:0] run_q;

	logic [CW-1:0]   ci;
	logic [SW:0]     cur;
	logic            cur_idle;
	logic [63:0]     e_dl, e_ls;
	logic [2:0]      e_lv;
	logic [31:0]     e_age;
	logic            elig, take, fifo_win;
	logic [SW:0]     newc;

	assign ci       = cmd_q.core[CW-1:0];
	assign cur      = cur_q[ci];
	assign cur_idle = cur[SW];
	assign e_dl  = (dl_q[idx_q] != 64'd0) ? dl_q[idx_q] : NO_DEADLINE;
	assign e_ls  = lsw_q[idx_q];
	assign e_lv  = level_q[idx_q];
	assign e_age = fifo_cnt_q - stamp_q[idx_q];
	assign elig  = queued_q[idx_q] && qcore_q[idx_q] == cmd_q.core
		&& (aff_q[idx_q] == AFF_ANY || aff_q[idx_q] == {1'b0, cmd_q.core});
	assign fifo_win = (e_lv != best_lv_q) ? (e_lv > best_lv_q) : (e_age > best_age_q);

	always_comb begin
		take = 1'b0;
		if (elig) begin
			if (pass_q == 2'd2) begin
				take = !found_q || fifo_win;
			end else if (!(pass_q == 2'd0 && !cur_idle && cur[SW-1:0] == idx_q)
				&& e_dl != NEVER_DEADLINE) begin
				if (!found_q) take = 1'b1;
				else if (e_dl != best_dl_q) take = e_dl < best_dl_q;
				else if (e_ls != best_ls_q) take = e_ls < best_ls_q;
				else take = fifo_win;
			end
		end
	end

	assign newc = found_q ? {1'b0, best_q} : {1'b1, {SW{1'b0}}};
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
		if (state_q == S_SCAN && take) begin
			best_q     <= idx_q;
			best_dl_q  <= e_dl;
			best_ls_q  <= e_ls;
			best_lv_q  <= e_lv;
			best_age_q <= e_age;
		end
		if (state_q == S_REQ && cmd_q.op == OP_ENQUEUE && 32'(cmd_q.slot) < TASK_SLOTS
			&& 32'(cmd_q.core) < CORE_COUNT && 32'(cmd_q.level) < PRIORITY_LEVELS
			&& !queued_q[cmd_q.slot[SW-1:0]]) begin
			qcore_q[cmd_q.slot[SW-1:0]] <= cmd_q.core;
			level_q[cmd_q.slot[SW-1:0]] <= cmd_q.level;
			aff_q[cmd_q.slot[SW-1:0]]   <= cmd_q.aff;
			dl_q[cmd_q.slot[SW-1:0]]    <= cmd_q.deadline;
			stamp_q[cmd_q.slot[SW-1:0]] <= fifo_cnt_q;
		end
		if (state_q == S_REQ && cmd_q.op != OP_ENQUEUE && cmd_q.op != OP_NONE
			&& 32'(cmd_q.core) < CORE_COUNT && !cur_idle
			&& (run_q[ci] && !(cmd_q.op == OP_EXIT)) && !queued_q[cur[SW-1:0]]) begin
			qcore_q[cur[SW-1:0]] <= cmd_q.core;
			stamp_q[cur[SW-1:0]] <= fifo_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= 2'd0;
			idx_q <= '0;
			found_q <= 1'b0;
			queued_q <= '0;
			fifo_cnt_q <= '0;
			sw_cnt_q <= '0;
			run_q <= '0;
			done <= 1'b0;
			cur_task <= '0;
			idle_selected <= 1'b0;
			switched <= 1'b0;
			rejected <= 1'b0;
			for (int i = 0; i < TASK_SLOTS; i++) lsw_q[i] <= '0;
			for (int c = 0; c < CORE_COUNT; c++) cur_q[c] <= {1'b1, {SW{1'b0}}};
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_REQ;
				end
				S_REQ: begin
					cur_task <= '0;
					idle_selected <= 1'b0;
					switched <= 1'b0;
					rejected <= 1'b0;
					if (cmd_q.op == OP_ENQUEUE) begin
						if (32'(cmd_q.slot) >= TASK_SLOTS || 32'(cmd_q.core) >= CORE_COUNT
							|| 32'(cmd_q.level) >= PRIORITY_LEVELS
							|| queued_q[cmd_q.slot[SW-1:0]]) begin
							rejected <= 1'b1;
						end else begin
							queued_q[cmd_q.slot[SW-1:0]] <= 1'b1;
							fifo_cnt_q <= fifo_cnt_q + 32'd1;
						end
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (cmd_q.op == OP_NONE || 32'(cmd_q.core) >= CORE_COUNT) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						if (!cur_idle && run_q[ci] && cmd_q.op != OP_EXIT
							&& !queued_q[cur[SW-1:0]]) begin
							queued_q[cur[SW-1:0]] <= 1'b1;
							fifo_cnt_q <= fifo_cnt_q + 32'd1;
						end
						pass_q <= 2'd0;
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (take) found_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (32'(idx_q) == TASK_SLOTS - 1) state_q <= S_PICK;
				end
				S_PICK: begin
					if (!found_q && pass_q != 2'd2) begin
						pass_q <= pass_q + 2'd1;
						idx_q <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (found_q) queued_q[best_q] <= 1'b0;
					if (newc != cur) begin
						cur_q[ci] <= newc;
						sw_cnt_q <= sw_cnt_q + 64'd1;
						if (found_q) lsw_q[best_q] <= sw_cnt_q + 64'd1;
						switched <= 1'b1;
					end
					run_q[ci] <= 1'b1;
					cur_task <= found_q ? 4'(best_q) : 4'd0;
					idle_selected <= !found_q;
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> state_q != S_OUT)
		else $error("result strobe overlaps output step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle_selected) |-> cur_task == 4'd0)
		else $error("idle result carries a task");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !(rejected && switched))
		else $error("enqueue and switch flagged together");
endmodule
`default_nettype wire

// ===== design/edf_task_scheduler.sv =====
// ============================================================================
// edf_task_scheduler: earliest-deadline-first scheduler for several cores
// Top level: command intake queue in front of the task-table engine.
// ============================================================================
// Issue a transaction by raising start while busy is low. Each transaction
// yields exactly one result, shown for one cycle with done high; the
// receiver cannot stall it. Enqueue and invalid commands finish in the
// request step. A schedule or exit walks the task table one slot per
// cycle, up to three passes (EDF skipping the caller, EDF allowing it,
// then highest level oldest), each pass a scan of every slot followed by
// a decision step, then an output step; the engine has a single comparator
// shared by all slots. A two-entry queue lets new commands land meanwhile.
`default_nettype none
module edf_task_scheduler
	import edf_pkg::*;
#(
	parameter int TASK_SLOTS      = DEF_TASK_SLOTS,
	parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
	parameter int CORE_COUNT      = DEF_CORE_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [1:0]  core,
	input  wire logic [3:0]  task_slot,
	input  wire logic [2:0]  priority_req,
	input  wire logic [2:0]  affinity,
	input  wire logic [63:0] deadline,
	output logic             done,
	output logic [3:0]       cur_task,
	output logic             idle_selected,
	output logic             switched,
	output logic             rejected
);
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	edf_front u_front (
		.clk, .arst_n, .start, .operation, .core, .task_slot, .priority_req,
		.affinity, .deadline, .busy, .cmd_valid, .cmd, .cmd_pop
	);

	edf_engine #(
		.TASK_SLOTS(TASK_SLOTS), .PRIORITY_LEVELS(PRIORITY_LEVELS),
		.CORE_COUNT(CORE_COUNT)
	) u_engine (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .done, .cur_task,
		.idle_selected, .switched, .rejected
	);
endmodule
`default_nettype wire

// ===== sim/edf_task_scheduler_tb.sv =====
// ============================================================================
// edf_task_scheduler_tb: self-checking testbench for the EDF task scheduler
// A behavioral scheduler model predicts each transaction's outcome; a
// directed pass covers extremes and corner cases, then random traffic runs
// under several sender idle ratios and the outcomes are checked in order.
// ============================================================================
`default_nettype none
module edf_task_scheduler_tb;
	import edf_pkg::*;

	localparam int SLOTS  = DEF_TASK_SLOTS;
	localparam int CORES  = DEF_CORE_COUNT;
	localparam int STALL_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [1:0]  core;
	logic [3:0]  task_slot;
	logic [2:0]  priority_req;
	logic [2:0]  affinity;
	logic [63:0] deadline;
	logic        done;
	logic [3:0]  cur_task;
	logic        idle_selected;
	logic        switched;
	logic        rejected;

	edf_task_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .core(core), .task_slot(task_slot),
		.priority_req(priority_req), .affinity(affinity), .deadline(deadline),
		.done(done), .cur_task(cur_task), .idle_selected(idle_selected),
		.switched(switched), .rejected(rejected)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// One outcome per transaction
	typedef struct {
		logic [3:0] task_id;
		logic       idle;
		logic       sw;
		logic       rej;
	} outcome_t;

	outcome_t outcome_q[$];
	int       errors;
	int       accepts_total;
	int       results_total;
	int       gap_pct;

	// ---------------------------------------------------------------------
	// Scheduler model state
	// ---------------------------------------------------------------------
	bit          tbl_queued[SLOTS];
	logic [1:0]  tbl_core[SLOTS];
	logic [2:0]  tbl_level[SLOTS];
	logic [2:0]  tbl_aff[SLOTS];
	logic [63:0] tbl_deadline[SLOTS];
	logic [63:0] tbl_last_sw[SLOTS];
	logic [31:0] tbl_fifo[SLOTS];
	logic [31:0] fifo_count;
	logic [63:0] switch_count;
	logic [4:0]  running_task[CORES];
	bit          running_flag[CORES];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_queued[i]  = 1'b0;
			tbl_last_sw[i] = '0;
		end
		for (int c = 0; c < CORES; c++) begin
			running_task[c] = 5'(SLOTS);
			running_flag[c] = 1'b0;
		end
		fifo_count   = '0;
		switch_count = '0;
	end

	function automatic logic [63:0] effective_deadline(int s);
		return (tbl_deadline[s] != 64'd0) ? tbl_deadline[s] : NO_DEADLINE;
	endfunction

	// affinity matches when "any" or equal to the core (values 4 to 6 never match)
	function automatic bit can_run_on(int s, logic [1:0] c);
		return tbl_queued[s] && tbl_core[s] == c &&
			(tbl_aff[s] == AFF_ANY || tbl_aff[s] == {1'b0, c});
	endfunction

	function automatic bit fifo_ahead(int a, int b);
		logic [31:0] age_a, age_b;
		age_a = fifo_count - tbl_fifo[a];
		age_b = fifo_count - tbl_fifo[b];
		if (tbl_level[a] != tbl_level[b])
			return tbl_level[a] > tbl_level[b];
		return age_a > age_b;
	endfunction

	function automatic bit deadline_ahead(int a, int b);
		if (effective_deadline(a) != effective_deadline(b))
			return effective_deadline(a) < effective_deadline(b);
		if (tbl_last_sw[a] != tbl_last_sw[b])
			return tbl_last_sw[a] < tbl_last_sw[b];
		return fifo_ahead(a, b);
	endfunction

	// EDF skipping the caller, EDF allowing it, then highest level oldest
	function automatic int pick_next(logic [1:0] c, int caller);
		int best;
		for (int pass = 0; pass < 2; pass++) begin
			best = -1;
			for (int s = 0; s < SLOTS; s++) begin
				if (can_run_on(s, c) && !(pass == 0 && s == caller) &&
						effective_deadline(s) != NEVER_DEADLINE &&
						(best < 0 || deadline_ahead(s, best)))
					best = s;
			end
			if (best >= 0)
				return best;
		end
		best = -1;
		for (int s = 0; s < SLOTS; s++)
			if (can_run_on(s, c) && (best < 0 || fifo_ahead(s, best)))
				best = s;
		return best;
	endfunction

	function automatic void queue_at_tail(int s, logic [1:0] c, logic [2:0] lvl);
		tbl_queued[s] = 1'b1;
		tbl_core[s]   = c;
		tbl_level[s]  = lvl;
		tbl_fifo[s]   = fifo_count;
		fifo_count++;
	endfunction

	function automatic outcome_t predict_outcome(op_t op, logic [1:0] c,
			logic [3:0] s, logic [2:0] lvl, logic [2:0] aff, logic [63:0] dl);
		outcome_t r;
		int cur;
		int nxt;
		r = '{task_id: 4'd0, idle: 1'b0, sw: 1'b0, rej: 1'b0};
		if (op == OP_ENQUEUE) begin
			if (tbl_queued[s]) begin
				r.rej = 1'b1;
				return r;
			end
			tbl_aff[s]      = aff;
			tbl_deadline[s] = dl;
			queue_at_tail(s, c, lvl);
			return r;
		end
		if (op == OP_NONE)
			return r;
		cur = running_task[c];
		if (op == OP_EXIT && cur < SLOTS)
			running_flag[c] = 1'b0;
		// preempted task goes back unless it was re-enqueued while running
		if (cur < SLOTS && running_flag[c] && !tbl_queued[cur])
			queue_at_tail(cur, c, tbl_level[cur]);
		nxt = pick_next(c, (cur < SLOTS) ? cur : -1);
		if (nxt >= 0)
			tbl_queued[nxt] = 1'b0;
		if (((nxt >= 0) ? nxt : SLOTS) != cur) begin
			running_task[c] = 5'((nxt >= 0) ? nxt : SLOTS);
			switch_count++;
			if (nxt >= 0)
				tbl_last_sw[nxt] = switch_count;
			r.sw = 1'b1;
		end
		running_flag[c] = 1'b1;
		r.task_id = (nxt >= 0) ? 4'(nxt) : 4'd0;
		r.idle    = (nxt < 0);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Sender: one transaction; busy is sampled at the falling edge
	// ---------------------------------------------------------------------
	task automatic send_cmd(op_t op, logic [1:0] c, logic [3:0] s,
			logic [2:0] lvl, logic [2:0] aff, logic [63:0] dl);
		bit taken;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start        <= 1'b1;
		operation    <= op;
		core         <= c;
		task_slot    <= s;
		priority_req <= lvl;
		affinity     <= aff;
		deadline     <= dl;
		do begin
			@(negedge clk);
			taken = !busy;
			if (taken) begin
				outcome_q.push_back(predict_outcome(op, c, s, lvl, aff, dl));
				accepts_total++;
			end
			@(posedge clk);
		end while (!taken);
	endtask

	// hold off until every outstanding transaction has completed
	task automatic drain_pending();
		start <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			results_total++;
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result task=%0d idle=%0d sw=%0d rej=%0d",
					$time, cur_task, idle_selected, switched, rejected);
				errors++;
			end else begin
				e = outcome_q.pop_front();
				if (cur_task !== e.task_id) begin
					$display("%0t: cur_task exp %0d got %0d", $time, e.task_id, cur_task);
					errors++;
				end
				if (idle_selected !== e.idle) begin
					$display("%0t: idle_selected exp %0d got %0d", $time, e.idle,
						idle_selected);
					errors++;
				end
				if (switched !== e.sw) begin
					$display("%0t: switched exp %0d got %0d", $time, e.sw, switched);
					errors++;
				end
				if (rejected !== e.rej) begin
					$display("%0t: rejected exp %0d got %0d", $time, e.rej, rejected);
					errors++;
				end
			end
		end
	end

	// Watchdog: too long with no transaction accepted and no result
	int idle_cycles;
	int seen_accepts;
	int seen_results;
	always @(posedge clk) begin
		if (accepts_total != seen_accepts || results_total != seen_results)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		seen_accepts <= accepts_total;
		seen_results <= results_total;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("edf_task_scheduler_tb: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Extremes of every field and of enqueue, schedule and exit
	task automatic test_directed_extremes();
		send_cmd(OP_ENQUEUE, 2'd0, 4'd0, 3'd7, AFF_ANY, 64'd0);
		send_cmd(OP_ENQUEUE, 2'd0, 4'd15, 3'd0, 3'd0, NO_DEADLINE);
		send_cmd(OP_ENQUEUE, 2'd3, 4'd5, 3'd4, 3'd3, 64'd1);
		send_cmd(OP_ENQUEUE, 2'd3, 4'd6, 3'd4, AFF_ANY, 64'd1);
		send_cmd(OP_SCHEDULE, 2'd0, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_SCHEDULE, 2'd0, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_SCHEDULE, 2'd3, 4'd15, 3'd7, 3'd7, '1);
		send_cmd(OP_SCHEDULE, 2'd3, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_EXIT, 2'd3, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_SCHEDULE, 2'd1, 4'd0, 3'd0, 3'd0, 64'd0);
	endtask

	// Double enqueue, odd affinity, never-deadline, exit while idle,
	// enqueue while running, ignored operation
	task automatic test_directed_corners();
		send_cmd(OP_ENQUEUE, 2'd2, 4'd9, 3'd2, 3'd2, 64'd100);
		send_cmd(OP_ENQUEUE, 2'd2, 4'd9, 3'd3, 3'd2, 64'd50);
		send_cmd(OP_ENQUEUE, 2'd2, 4'd10, 3'd6, 3'd4, 64'd1);
		send_cmd(OP_ENQUEUE, 2'd2, 4'd11, 3'd1, 3'd6, 64'd1);
		send_cmd(OP_ENQUEUE, 2'd2, 4'd12, 3'd5, 3'd2, NEVER_DEADLINE);
		send_cmd(OP_SCHEDULE, 2'd2, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_ENQUEUE, 2'd2, 4'd9, 3'd2, 3'd2, 64'd100);
		send_cmd(OP_SCHEDULE, 2'd2, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_EXIT, 2'd2, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_EXIT, 2'd1, 4'd0, 3'd0, 3'd0, 64'd0);
		send_cmd(OP_NONE, 2'd3, 4'd15, 3'd7, 3'd7, '1);
		send_cmd(OP_EXIT, 2'd2, 4'd0, 3'd0, 3'd0, 64'd0);
	endtask

	function automatic logic [63:0] random_deadline();
		int pick;
		pick = $urandom_range(15);
		case (pick)
			0, 1: return 64'd0;
			2: return NEVER_DEADLINE;
			3: return NO_DEADLINE;
			4: return {$urandom, $urandom};
			default: return 64'($urandom_range(1, 20));
		endcase
	endfunction

	// Mixed traffic; enqueue core mostly matches the task's affinity
	task automatic test_random_traffic(int count, int idle_pct);
		int roll;
		logic [1:0] c;
		logic [2:0] aff;
		gap_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			c    = 2'($urandom_range(CORES - 1));
			if (roll < 48) begin
				aff = ($urandom_range(2) == 0) ? AFF_ANY : 3'($urandom_range(3));
				if (aff != AFF_ANY && $urandom_range(9) < 7)
					c = aff[1:0];
				send_cmd(OP_ENQUEUE, c, 4'($urandom_range(15)), 3'($urandom_range(7)),
					aff, random_deadline());
			end else if (roll < 85) begin
				send_cmd(OP_SCHEDULE, c, 4'($urandom), 3'($urandom), 3'($urandom),
					{$urandom, $urandom});
			end else if (roll < 98) begin
				send_cmd(OP_EXIT, c, 4'($urandom), 3'($urandom), 3'($urandom),
					{$urandom, $urandom});
			end else begin
				send_cmd(OP_NONE, c, 4'($urandom), 3'($urandom), 3'($urandom),
					{$urandom, $urandom});
			end
		end
		gap_pct = 0;
	endtask

	initial begin
		errors        = 0;
		accepts_total = 0;
		results_total = 0;
		gap_pct       = 0;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		operation    <= OP_ENQUEUE;
		core         <= '0;
		task_slot    <= '0;
		priority_req <= '0;
		affinity     <= '0;
		deadline     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_directed_corners();
		test_random_traffic(200, 0);
		drain_pending();
		test_random_traffic(150, 75);
		test_random_traffic(150, 22);
		drain_pending();
		test_random_traffic(150, $urandom_range(40));

		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("edf_task_scheduler_tb: PASS");
		else
			$display("edf_task_scheduler_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
